// ===== hdl/pcg_pkg.sv =====
// Shared types, codes and constant tables of the pixel color grading block.
package pcg_pkg;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_TONE  = 2'd1;
  localparam logic [1:0] KIND_ALPHA = 2'd2;

  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;
  localparam logic [1:0] CHAN_NONE  = 2'd3;

  localparam logic [1:0] HUE_RED   = 2'd0;
  localparam logic [1:0] HUE_GREEN = 2'd1;
  localparam logic [1:0] HUE_BLUE  = 2'd2;

  localparam logic [2:0] CFG_HSV_ENABLE        = 3'd0;
  localparam logic [2:0] CFG_HUE_SHIFT         = 3'd1;
  localparam logic [2:0] CFG_SATURATION_GAIN   = 3'd2;
  localparam logic [2:0] CFG_BRIGHTNESS_OFFSET = 3'd3;
  localparam logic [2:0] CFG_PRESET_ENABLE     = 3'd4;
  localparam logic [2:0] CFG_PRESET_COLOR      = 3'd5;
  localparam logic [2:0] CFG_PRESET_THRESHOLD  = 3'd6;

  localparam logic [18:0] TURN6           = 19'd393216;
  localparam logic [18:0] HUE_BASE_GREEN  = 19'd131072;
  localparam logic [18:0] HUE_BASE_BLUE   = 19'd262144;
  localparam logic [21:0] LUMA_R          = 22'd2126;
  localparam logic [21:0] LUMA_G          = 22'd7152;
  localparam logic [21:0] LUMA_B          = 22'd722;
  localparam logic [38:0] THRESHOLD_SCALE = 39'd2550000;

  localparam int DIV_Q_W   = 17;
  localparam int DIV_NUM_W = 8 + DIV_Q_W;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] table_channel;
    logic [7:0] table_index;
    logic [7:0] table_value;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pcg_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pcg_out_t;

  typedef struct packed {
    logic       is_pix;
    logic       tone_ld;
    logic       alpha_ld;
    logic [1:0] chan;
    logic [7:0] idx;
    logic [7:0] val;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] mx;
    logic [7:0] d;
    logic [1:0] sel;
    logic       hneg;
    logic [7:0] hmag;
    logic [7:0] vv;
  } item_t;

  typedef logic [15:0] vtab_t [256];

  function automatic vtab_t build_vtab();
    vtab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 16'((i * 65536 + 255) / 510);
    end
    return t;
  endfunction

endpackage

// ===== hdl/pcg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module pcg_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [pcg_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [7:0]                   den_i,
  output logic [pcg_pkg::DIV_Q_W-1:0]   quo_o
);

  localparam int Q = pcg_pkg::DIV_Q_W;

  logic [7:0]   rem_q [Q];
  logic [Q-1:0] low_q [Q];
  logic [Q-1:0] quo_q [Q];
  logic [7:0]   den_q [Q];

  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic [7:0]   rem_s;
    logic [7:0]   den_s;
    logic [Q-1:0] low_s;
    logic [Q-1:0] quo_s;
    logic [8:0]   trial;
    logic         take;

    if (k == 0) begin : g_first
      assign rem_s = num_i[pcg_pkg::DIV_NUM_W-1:Q];
      assign low_s = num_i[Q-1:0];
      assign quo_s = '0;
      assign den_s = den_i;
    end else begin : g_next
      assign rem_s = rem_q[k-1];
      assign low_s = low_q[k-1];
      assign quo_s = quo_q[k-1];
      assign den_s = den_q[k-1];
    end

    assign trial = {rem_s, low_s[Q-1]};
    assign take  = trial >= {1'b0, den_s};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? 8'(trial - {1'b0, den_s}) : trial[7:0];
        low_q[k] <= {low_s[Q-2:0], 1'b0};
        quo_q[k] <= {quo_s[Q-2:0], take};
        den_q[k] <= den_s;
      end
    end
  end

  assign quo_o = quo_q[Q-1];

endmodule

// ===== hdl/pixel_color_grade_recolor.sv =====
// Top level of the pixel color grading and recolor pipeline.
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | pcg_in_t (pixel or curve load)
//   out     | output    | out_valid/out_ready| pcg_out_t (graded pixel)
//   cfg     | input     | cfg_we             | cfg_idx, cfg_data
// One transaction per cycle while the output is not stalled; a pixel result passes through
// the 17-stage hue and saturation dividers and the curve memory reads.
// Curve loads pass down the pipe and write where pixels read, so order holds.
// Reset clears valid bits and config registers; the curve memories are not cleared.
// A result not taken stalls the whole pipe; in_ready follows that stall.
module pixel_color_grade_recolor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pcg_pkg::pcg_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pcg_pkg::pcg_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [23:0]       cfg_data_i
);

  localparam int DS = pcg_pkg::DIV_Q_W;
  localparam pcg_pkg::vtab_t VTAB = pcg_pkg::build_vtab();

  logic        hsv_en_q, preset_en_q;
  logic [11:0] hue_shift_q;
  logic [15:0] sat_gain_q;
  logic [15:0] bright_q;
  logic [23:0] preset_color_q;
  logic [16:0] preset_thr_q;
  logic [38:0] thr_scaled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsv_en_q       <= 1'b0;
      hue_shift_q    <= '0;
      sat_gain_q     <= 16'd256;
      bright_q       <= '0;
      preset_en_q    <= 1'b0;
      preset_color_q <= '0;
      preset_thr_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcg_pkg::CFG_HSV_ENABLE:        hsv_en_q       <= cfg_data_i[0];
        pcg_pkg::CFG_HUE_SHIFT:         hue_shift_q    <= cfg_data_i[11:0];
        pcg_pkg::CFG_SATURATION_GAIN:   sat_gain_q     <= cfg_data_i[15:0];
        pcg_pkg::CFG_BRIGHTNESS_OFFSET: bright_q       <= cfg_data_i[15:0];
        pcg_pkg::CFG_PRESET_ENABLE:     preset_en_q    <= cfg_data_i[0];
        pcg_pkg::CFG_PRESET_COLOR:      preset_color_q <= cfg_data_i;
        pcg_pkg::CFG_PRESET_THRESHOLD:  preset_thr_q   <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    thr_scaled_q <= {22'b0, preset_thr_q} * pcg_pkg::THRESHOLD_SCALE;
  end

  logic en;
  logic out_valid_q;
  pcg_pkg::pcg_out_t out_data_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Input decode: max, min and hue operands
  pcg_pkg::item_t in_item;
  logic [7:0] mn, hx, hy;

  always_comb begin
    in_item          = '0;
    in_item.is_pix   = in_data_i.kind == pcg_pkg::KIND_PIXEL;
    in_item.tone_ld  = in_data_i.kind == pcg_pkg::KIND_TONE &&
                       in_data_i.table_channel != pcg_pkg::CHAN_NONE;
    in_item.alpha_ld = in_data_i.kind == pcg_pkg::KIND_ALPHA;
    in_item.chan     = in_data_i.table_channel;
    in_item.idx      = in_data_i.table_index;
    in_item.val      = in_data_i.table_value;
    in_item.red      = in_data_i.red_in;
    in_item.green    = in_data_i.green_in;
    in_item.blue     = in_data_i.blue_in;
    in_item.alpha    = in_data_i.alpha_in;
    priority if (in_data_i.red_in >= in_data_i.green_in &&
                 in_data_i.red_in >= in_data_i.blue_in) begin
      in_item.sel = pcg_pkg::HUE_RED;
      in_item.mx  = in_data_i.red_in;
      hx          = in_data_i.green_in;
      hy          = in_data_i.blue_in;
    end else if (in_data_i.green_in >= in_data_i.blue_in) begin
      in_item.sel = pcg_pkg::HUE_GREEN;
      in_item.mx  = in_data_i.green_in;
      hx          = in_data_i.blue_in;
      hy          = in_data_i.red_in;
    end else begin
      in_item.sel = pcg_pkg::HUE_BLUE;
      in_item.mx  = in_data_i.blue_in;
      hx          = in_data_i.red_in;
      hy          = in_data_i.green_in;
    end
    mn = in_data_i.red_in;
    if (in_data_i.green_in < mn) mn = in_data_i.green_in;
    if (in_data_i.blue_in < mn) mn = in_data_i.blue_in;
    in_item.d    = in_item.mx - mn;
    in_item.hneg = hx < hy;
    in_item.hmag = (hx < hy) ? hy - hx : hx - hy;
  end

  logic           s1_vld_q;
  pcg_pkg::item_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (en) s1_vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) s1_q <= in_item;
  end

  // Value term and divider operands
  pcg_pkg::item_t dl_in;
  logic [15:0] vt, vcl;
  logic signed [17:0] vsum;
  logic [23:0] vprod;
  logic [pcg_pkg::DIV_NUM_W-1:0] hue_num, sat_num;

  always_comb begin
    vt   = VTAB[s1_q.mx];
    vsum = $signed({2'b00, vt}) + $signed({{2{bright_q[15]}}, bright_q});
    if (vsum < 18'sd0) vcl = '0;
    else if (vsum > 18'sd32768) vcl = 16'd32768;
    else vcl = vsum[15:0];
    vprod = {vcl, 8'b0} - {8'b0, vcl} + 24'd16384;
    dl_in    = s1_q;
    dl_in.vv = vprod[22:15];
    hue_num  = {1'b0, s1_q.hmag, 16'b0} + {18'b0, s1_q.d[7:1]};
    sat_num  = {1'b0, s1_q.d, 16'b0} + {18'b0, s1_q.mx[7:1]};
  end

  logic [DS-1:0] hue_q, sat_q;

  pcg_div u_hue_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (hue_num),
    .den_i (s1_q.d),
    .quo_o (hue_q)
  );

  pcg_div u_sat_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sat_num),
    .den_i (s1_q.mx),
    .quo_o (sat_q)
  );

  logic           dl_vld_q [DS];
  pcg_pkg::item_t dl_q     [DS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DS; k++) dl_vld_q[k] <= 1'b0;
    end else if (en) begin
      dl_vld_q[0] <= s1_vld_q;
      for (int k = 1; k < DS; k++) dl_vld_q[k] <= dl_vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q[0] <= dl_in;
      for (int k = 1; k < DS; k++) dl_q[k] <= dl_q[k-1];
    end
  end

  // Hue wrap and shift, saturation gain product
  pcg_pkg::item_t dl_o;
  logic [18:0] base, h0, sh96, h6_d;
  logic signed [20:0] hs;
  logic [19:0] hsum;
  logic [16:0] sraw;
  logic [32:0] prod_d;

  always_comb begin
    dl_o = dl_q[DS-1];
    unique case (dl_o.sel)
      pcg_pkg::HUE_GREEN: base = pcg_pkg::HUE_BASE_GREEN;
      pcg_pkg::HUE_BLUE:  base = pcg_pkg::HUE_BASE_BLUE;
      default:            base = '0;
    endcase
    if (dl_o.hneg) hs = $signed({2'b00, base}) - $signed({4'b0, hue_q});
    else hs = $signed({2'b00, base}) + $signed({4'b0, hue_q});
    if (hs < 21'sd0) hs = hs + $signed({2'b00, pcg_pkg::TURN6});
    h0   = (dl_o.d == 8'd0) ? 19'd0 : hs[18:0];
    sh96 = {1'b0, hue_shift_q, 6'b0} + {2'b0, hue_shift_q, 5'b0};
    hsum = {1'b0, h0} + {1'b0, sh96};
    if (hsum >= {1'b0, pcg_pkg::TURN6}) hsum = hsum - {1'b0, pcg_pkg::TURN6};
    h6_d   = hsum[18:0];
    sraw   = (dl_o.mx == 8'd0) ? 17'd0 : sat_q;
    prod_d = {16'b0, sraw} * {17'b0, sat_gain_q};
  end

  logic vld_q [8];
  pcg_pkg::item_t p1_q, p2_q, p3_q, p4_q, p5_q, p6_q, p7_q, p8_q;
  logic [18:0] h6_p1_q, h6_p2_q, h6_p3_q, h6_p4_q;
  logic [32:0] prod_p1_q, sf_p3_q;
  logic [16:0] s_p2_q;
  logic [24:0] vs_p3_q, vs_p4_q;
  logic [40:0] vsf_p4_q;
  logic [7:0]  gr_r_p5_q, gr_g_p5_q, gr_b_p5_q;
  logic [7:0]  tone_r_q, tone_g_q, tone_b_q;
  logic [21:0] luma_p7_q;
  logic [7:0]  tr_p7_q, tg_p7_q, tb_p7_q, tr_p8_q, tg_p8_q, tb_p8_q;
  logic [7:0]  alpha_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 8; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= dl_vld_q[DS-1];
      for (int k = 1; k < 8; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Saturation clamp
  logic [32:0] sg;
  logic [16:0] s_d;
  always_comb begin
    sg  = prod_p1_q + 33'd128;
    s_d = (sg[32:8] > 25'd65536) ? 17'd65536 : sg[24:8];
  end

  // Rebuild RGB from hue sector
  logic [25:0] pw;
  logic [41:0] qw, tw;
  logic [7:0]  pv, qv, tv, vv5, hr, hg, hb;
  always_comb begin
    vv5 = p4_q.vv;
    pw  = {2'b0, vv5, 16'b0} - {1'b0, vs_p4_q} + 26'd32768;
    qw  = {2'b0, vv5, 32'b0} - {1'b0, vsf_p4_q} + 42'h0_8000_0000;
    tw  = {2'b0, vv5, 32'b0} - {1'b0, vs_p4_q, 16'b0} + {1'b0, vsf_p4_q} +
          42'h0_8000_0000;
    pv  = pw[23:16];
    qv  = qw[39:32];
    tv  = tw[39:32];
    unique case (h6_p4_q[18:16])
      3'd0:    begin hr = vv5; hg = tv;  hb = pv;  end
      3'd1:    begin hr = qv;  hg = vv5; hb = pv;  end
      3'd2:    begin hr = pv;  hg = vv5; hb = tv;  end
      3'd3:    begin hr = pv;  hg = qv;  hb = vv5; end
      3'd4:    begin hr = tv;  hg = pv;  hb = vv5; end
      default: begin hr = vv5; hg = pv;  hb = qv;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q      <= dl_o;
      h6_p1_q   <= h6_d;
      prod_p1_q <= prod_d;
      p2_q      <= p1_q;
      h6_p2_q   <= h6_p1_q;
      s_p2_q    <= s_d;
      p3_q      <= p2_q;
      h6_p3_q   <= h6_p2_q;
      vs_p3_q   <= {17'b0, p2_q.vv} * {8'b0, s_p2_q};
      sf_p3_q   <= {16'b0, s_p2_q} * {17'b0, h6_p2_q[15:0]};
      p4_q      <= p3_q;
      h6_p4_q   <= h6_p3_q;
      vs_p4_q   <= vs_p3_q;
      vsf_p4_q  <= {33'b0, p3_q.vv} * {8'b0, sf_p3_q};
      p5_q      <= p4_q;
      gr_r_p5_q <= hsv_en_q ? hr : p4_q.red;
      gr_g_p5_q <= hsv_en_q ? hg : p4_q.green;
      gr_b_p5_q <= hsv_en_q ? hb : p4_q.blue;
    end
  end

  // Tone curve memories: loads write at the read stage
  logic [7:0] tone_r_mem [256];
  logic [7:0] tone_g_mem [256];
  logic [7:0] tone_b_mem [256];
  logic       tone_wr;

  assign tone_wr = en && vld_q[4] && p5_q.tone_ld;

  always_ff @(posedge clk_i) begin
    if (tone_wr && p5_q.chan == pcg_pkg::CHAN_RED) tone_r_mem[p5_q.idx] <= p5_q.val;
    if (en) tone_r_q <= tone_r_mem[gr_r_p5_q];
  end

  always_ff @(posedge clk_i) begin
    if (tone_wr && p5_q.chan == pcg_pkg::CHAN_GREEN) tone_g_mem[p5_q.idx] <= p5_q.val;
    if (en) tone_g_q <= tone_g_mem[gr_g_p5_q];
  end

  always_ff @(posedge clk_i) begin
    if (tone_wr && p5_q.chan == pcg_pkg::CHAN_BLUE) tone_b_mem[p5_q.idx] <= p5_q.val;
    if (en) tone_b_q <= tone_b_mem[gr_b_p5_q];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p6_q      <= p5_q;
      p7_q      <= p6_q;
      luma_p7_q <= {14'b0, tone_r_q} * pcg_pkg::LUMA_R +
                   {14'b0, tone_g_q} * pcg_pkg::LUMA_G +
                   {14'b0, tone_b_q} * pcg_pkg::LUMA_B;
      tr_p7_q   <= tone_r_q;
      tg_p7_q   <= tone_g_q;
      tb_p7_q   <= tone_b_q;
      p8_q      <= p7_q;
      tr_p8_q   <= tr_p7_q;
      tg_p8_q   <= tg_p7_q;
      tb_p8_q   <= tb_p7_q;
    end
  end

  // Luma threshold and alpha curve
  logic       dark;
  logic [7:0] a_eff;
  logic [7:0] alpha_mem [256];

  assign dark  = {1'b0, luma_p7_q, 16'b0} < thr_scaled_q;
  assign a_eff = dark ? 8'd0 : p7_q.alpha;

  always_ff @(posedge clk_i) begin
    if (en && vld_q[6] && p7_q.alpha_ld) alpha_mem[p7_q.idx] <= p7_q.val;
    if (en) alpha_rd_q <= alpha_mem[a_eff];
  end

  pcg_pkg::pcg_out_t out_d;
  always_comb begin
    priority if (p8_q.alpha == 8'd0) begin
      out_d = {p8_q.red, p8_q.green, p8_q.blue, p8_q.alpha};
    end else if (preset_en_q) begin
      out_d = {preset_color_q, alpha_rd_q};
    end else begin
      out_d = {tr_p8_q, tg_p8_q, tb_p8_q, p8_q.alpha};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= vld_q[7] && p8_q.is_pix;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_data_q <= out_d;
  end

endmodule

// ===== sim/pcg_grade_checker.sv =====
// Checker for the color grading block: predicts each graded pixel and compares results.
module pcg_grade_checker
  import pcg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  pcg_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  pcg_out_t out_data_i,
  input  logic     cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  output int       fail_count_o,
  output int       pending_o,
  output int       checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] tone_lut [768];
  logic [7:0] alpha_lut [256];
  logic        hsv_on;
  logic [11:0] hue_rot;
  logic [15:0] sat_gain;
  logic signed [15:0] val_offset;
  logic        recolor_on;
  logic [23:0] recolor_rgb;
  logic [16:0] luma_floor;

  pcg_out_t expected_pixels [$];

  function automatic int round_div(int num, int den);
    int mag;
    int q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic pcg_out_t grade_pixel(pcg_in_t px);
    pcg_out_t res;
    int r, g, b, a, mx, mn, d, h6, v, vq, sector, f;
    longint s, sg, p, q, t, luma;
    r = px.red_in;
    g = px.green_in;
    b = px.blue_in;
    a = px.alpha_in;
    if (a != 0) begin
      if (hsv_on) begin
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        h6 = 0;
        if (d != 0) begin
          if (mx == r) h6 = round_div((g - b) * 65536, d);
          else if (mx == g) h6 = 131072 + round_div((b - r) * 65536, d);
          else h6 = 262144 + round_div((r - g) * 65536, d);
          if (h6 < 0) h6 += 393216;
          if (h6 >= 393216) h6 -= 393216;
        end
        h6 = (h6 + int'(hue_rot) * 96) % 393216;
        s = (mx == 0) ? 0 : (longint'(d) * 65536 + mx / 2) / mx;
        sg = (s * longint'(sat_gain) + 128) >>> 8;
        s = (sg > 65536) ? 65536 : sg;
        v = (mx * 65536 + 255) / 510 + int'(val_offset);
        if (v < 0) v = 0;
        if (v > 32768) v = 32768;
        vq = (v * 255 + 16384) >>> 15;
        sector = h6 >>> 16;
        f = h6 & 65535;
        p = (longint'(vq) * (65536 - s) + 32768) >>> 16;
        q = (longint'(vq) * (64'h1_0000_0000 - s * f) + 64'h8000_0000) >>> 32;
        t = (longint'(vq) * (64'h1_0000_0000 - s * (65536 - f)) + 64'h8000_0000) >>> 32;
        case (sector)
          0: begin r = vq; g = t; b = p; end
          1: begin r = q; g = vq; b = p; end
          2: begin r = p; g = vq; b = t; end
          3: begin r = p; g = q; b = vq; end
          4: begin r = t; g = p; b = vq; end
          default: begin r = vq; g = p; b = q; end
        endcase
        r &= 255; g &= 255; b &= 255;
      end
      r = tone_lut[r];
      g = tone_lut[256 + g];
      b = tone_lut[512 + b];
      if (recolor_on) begin
        luma = (2126 * longint'(r) + 7152 * longint'(g) + 722 * longint'(b)) * 65536;
        if (luma < longint'(luma_floor) * 2550000) a = 0;
        a = alpha_lut[a];
        r = recolor_rgb[23:16];
        g = recolor_rgb[15:8];
        b = recolor_rgb[7:0];
      end
    end
    res.red_out   = r[7:0];
    res.green_out = g[7:0];
    res.blue_out  = b[7:0];
    res.alpha_out = a[7:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pcg_out_t want;
    if (!rst_ni) begin
      hsv_on = 1'b0;
      hue_rot = '0;
      sat_gain = 16'd256;
      val_offset = '0;
      recolor_on = 1'b0;
      recolor_rgb = '0;
      luma_floor = '0;
      fail_count_o = 0;
      checked_o = 0;
      pending_o = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HSV_ENABLE:        hsv_on = cfg_data_i[0];
          CFG_HUE_SHIFT:         hue_rot = cfg_data_i[11:0];
          CFG_SATURATION_GAIN:   sat_gain = cfg_data_i[15:0];
          CFG_BRIGHTNESS_OFFSET: val_offset = cfg_data_i[15:0];
          CFG_PRESET_ENABLE:     recolor_on = cfg_data_i[0];
          CFG_PRESET_COLOR:      recolor_rgb = cfg_data_i;
          CFG_PRESET_THRESHOLD:  luma_floor = cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_i);
          fail_count_o++;
        end else begin
          want = expected_pixels.pop_front();
          if (want.red_out !== out_data_i.red_out) begin
            $display("%0t: red expected %h actual %h", $time, want.red_out, out_data_i.red_out);
            fail_count_o++;
          end
          if (want.green_out !== out_data_i.green_out) begin
            $display("%0t: green expected %h actual %h", $time, want.green_out,
                     out_data_i.green_out);
            fail_count_o++;
          end
          if (want.blue_out !== out_data_i.blue_out) begin
            $display("%0t: blue expected %h actual %h", $time, want.blue_out,
                     out_data_i.blue_out);
            fail_count_o++;
          end
          if (want.alpha_out !== out_data_i.alpha_out) begin
            $display("%0t: alpha expected %h actual %h", $time, want.alpha_out,
                     out_data_i.alpha_out);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (in_data_i.kind)
          KIND_PIXEL: expected_pixels.push_back(grade_pixel(in_data_i));
          KIND_TONE:
            if (in_data_i.table_channel != CHAN_NONE)
              tone_lut[in_data_i.table_channel * 256 + in_data_i.table_index] =
                in_data_i.table_value;
          KIND_ALPHA: alpha_lut[in_data_i.table_index] = in_data_i.table_value;
          default: ;
        endcase
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

// ===== sim/pixel_color_grade_recolor_tb.sv =====
// Testbench top for the color grading block: stimulus, flow control and verdict.
module pixel_color_grade_recolor_tb;
  import pcg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        hsv;
    logic [11:0] hue;
    logic [15:0] gain;
    logic [15:0] offset;
    logic        recolor;
    logic [23:0] color;
    logic [16:0] floor;
  } grade_setting_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pcg_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pcg_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [23:0] cfg_data = '0;
  int          fail_count, pending, checked;
  int          sent = 0, settings_used = 0, idle_cycles = 0;
  bit          calm = 0, long_hold = 0;

  pixel_color_grade_recolor uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  pcg_grade_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_item(pcg_in_t item);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (35) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(grade_setting_t st);
    write_reg(CFG_HSV_ENABLE, {23'd0, st.hsv});
    write_reg(CFG_HUE_SHIFT, {12'd0, st.hue});
    write_reg(CFG_SATURATION_GAIN, {8'd0, st.gain});
    write_reg(CFG_BRIGHTNESS_OFFSET, {8'd0, st.offset});
    write_reg(CFG_PRESET_ENABLE, {23'd0, st.recolor});
    write_reg(CFG_PRESET_COLOR, st.color);
    write_reg(CFG_PRESET_THRESHOLD, {7'd0, st.floor});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic pcg_in_t make_pixel(int r, int g, int b, int a);
    pcg_in_t it;
    it = '0;
    it.kind = KIND_PIXEL;
    it.table_channel = 2'($urandom);
    it.table_index = 8'($urandom);
    it.table_value = 8'($urandom);
    it.red_in = 8'(r);
    it.green_in = 8'(g);
    it.blue_in = 8'(b);
    it.alpha_in = 8'(a);
    return it;
  endfunction

  function automatic pcg_in_t random_item();
    pcg_in_t it;
    int sel, c;
    sel = $urandom_range(0, 99);
    c = $urandom_range(0, 255);
    it = make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 15) * 17);
    if (sel < 8) it.alpha_in = 8'd0;
    else if (sel < 14) it.alpha_in = 8'd255;
    else if (sel < 20) begin
      it.red_in = 8'(c); it.green_in = 8'(c); it.blue_in = 8'(c);
    end else if (sel < 27) begin
      it.kind = KIND_TONE;
      it.table_channel = 2'($urandom_range(0, 3));
    end else if (sel < 31) it.kind = KIND_ALPHA;
    else if (sel < 33) it.kind = 2'd3;
    return it;
  endfunction

  task automatic run_directed();
    pcg_in_t it;
    push_item(make_pixel(0, 0, 0, 255));
    push_item(make_pixel(255, 255, 255, 17));
    push_item(make_pixel(255, 0, 0, 136));
    push_item(make_pixel(0, 255, 0, 204));
    push_item(make_pixel(0, 0, 255, 68));
    push_item(make_pixel(200, 200, 10, 255));
    push_item(make_pixel(10, 200, 200, 255));
    push_item(make_pixel(200, 10, 200, 255));
    push_item(make_pixel(1, 0, 0, 255));
    push_item(make_pixel(255, 254, 253, 0));
    push_item(make_pixel(90, 30, 60, 0));
    it = make_pixel(1, 2, 3, 4);
    it.kind = 2'd3;
    push_item(it);
    it = make_pixel(1, 2, 3, 4);
    it.kind = KIND_TONE;
    it.table_channel = CHAN_NONE;
    push_item(it);
  endtask

  initial begin
    grade_setting_t st;
    pcg_in_t it;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 768; i++) begin
      it = '0;
      it.kind = KIND_TONE;
      it.table_channel = 2'((i / 256) % 4);
      it.table_index = 8'(i % 256);
      it.table_value = 8'($urandom);
      push_item(it);
    end
    for (int k = 0; k < 16; k++) begin
      it = '0;
      it.kind = KIND_ALPHA;
      it.table_index = 8'(k * 17);
      it.table_value = 8'($urandom);
      push_item(it);
    end
    drain();

    st = '{1'b1, 12'd0, 16'd256, 16'd0, 1'b0, 24'd0, 17'd0};
    apply_setting(st);
    run_directed();
    drain();
    st = '{1'b1, 12'd4095, 16'd65535, 16'h7fff, 1'b1, 24'hffffff, 17'd32768};
    apply_setting(st);
    run_directed();
    drain();
    st = '{1'b1, 12'd2048, 16'd0, 16'h8000, 1'b1, 24'h000000, 17'h1ffff};
    apply_setting(st);
    run_directed();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      st.hsv = 1'($urandom);
      st.hue = 12'($urandom);
      st.gain = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 768));
      st.offset = 16'($urandom);
      st.recolor = 1'($urandom);
      st.color = 24'($urandom);
      st.floor = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      if (ph == 1) st = '{1'b0, 12'd0, 16'd256, 16'd0, 1'b1, 24'h123456, 17'd0};
      calm = (ph == 5);
      apply_setting(st);
      for (int n = 0; n < 46; n++) begin
        if (ph == 2 && n == 10) long_hold = 1;
        push_item(random_item());
      end
      drain();
    end

    $display("Sent %0d transactions (curve loads, pixels, ignored kinds) over %0d settings;",
             sent, settings_used);
    $display("compared %0d graded pixels including a long output stall.", checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pcg_pkg.sv
hdl/pcg_div.sv
hdl/pixel_color_grade_recolor.sv
sim/pcg_grade_checker.sv
sim/pixel_color_grade_recolor_tb.sv
